FILE: rtl/coincidence_event_builder_defines.svh
// ----------------------------------------------------------------------------
// Coincidence event builder assertion macros
// Shared concurrent assertion forms, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef COINCIDENCE_EVENT_BUILDER_DEFINES_SVH
`define COINCIDENCE_EVENT_BUILDER_DEFINES_SVH

// same-cycle implication
`define CEB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("event builder check failed");

// next-cycle implication
`define CEB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("event builder check failed");

`endif

FILE: rtl/ceb_pkg.sv
// ----------------------------------------------------------------------------
// Coincidence event builder package
// Widths, register indexes, codes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package ceb_pkg;

  localparam int MAX_HITS_DEF   = 32;
  localparam int STAMP_BITS_DEF = 48;

  localparam int ID_W       = 16;
  localparam int EN_W       = 16;
  localparam int WIN_W      = 16;
  localparam int EVNUM_W    = 32;
  localparam int CNT_OUT_W  = 6;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [WIN_W-1:0] WINDOW_RST = 16'd100;
  localparam logic [ID_W-1:0]  LIMIT_RST  = 16'd0;

  localparam logic KIND_HIT   = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 8'd1;

  typedef struct packed {
    logic [WIN_W-1:0] window;
    logic [ID_W-1:0]  limit;
  } ceb_cfg_t;

endpackage

`default_nettype wire

FILE: rtl/ceb_in_if.sv
// ----------------------------------------------------------------------------
// Hit input channel
// Valid/ready channel carrying one hit or flush word.
// ----------------------------------------------------------------------------
`default_nettype none

interface ceb_in_if
  import ceb_pkg::*;
#(
  parameter int STAMP_BITS = STAMP_BITS_DEF
) ();

  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [ID_W-1:0]       det_id;
  logic [EN_W-1:0]       energy;
  logic [STAMP_BITS-1:0] hit_time;

  modport source (output valid, kind, det_id, energy, hit_time, input ready);
  modport sink   (input valid, kind, det_id, energy, hit_time, output ready);

endinterface

`default_nettype wire

FILE: rtl/ceb_out_if.sv
// ----------------------------------------------------------------------------
// Event output channel
// Valid/ready channel carrying one emitted hit word of an event.
// ----------------------------------------------------------------------------
`default_nettype none

interface ceb_out_if
  import ceb_pkg::*;
#(
  parameter int STAMP_BITS = STAMP_BITS_DEF
) ();

  logic                  valid;
  logic                  ready;
  logic [EVNUM_W-1:0]    event_number;
  logic [ID_W-1:0]       hit_det_id;
  logic [EN_W-1:0]       hit_energy;
  logic [STAMP_BITS-1:0] hit_stamp;
  logic [CNT_OUT_W-1:0]  event_hits;
  logic [CNT_OUT_W-1:0]  event_crystal_hits;
  logic                  last_of_event;
  logic                  hits_dropped;

  modport source (
    output valid, event_number, hit_det_id, hit_energy, hit_stamp,
           event_hits, event_crystal_hits, last_of_event, hits_dropped,
    input  ready
  );
  modport sink (
    input  valid, event_number, hit_det_id, hit_energy, hit_stamp,
           event_hits, event_crystal_hits, last_of_event, hits_dropped,
    output ready
  );

endinterface

`default_nettype wire

FILE: rtl/ceb_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface ceb_cfg_if
  import ceb_pkg::*;
();

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);

endinterface

`default_nettype wire

FILE: rtl/ceb_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ceb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ceb_seq.sv
// ----------------------------------------------------------------------------
// Coincidence event builder sequencer
// Window test, hit buffering into RAM, event readout and output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "coincidence_event_builder_defines.svh"

module ceb_seq
  import ceb_pkg::*;
#(
  parameter int MAX_HITS   = MAX_HITS_DEF,
  parameter int STAMP_BITS = STAMP_BITS_DEF,
  localparam int AW        = $clog2(MAX_HITS),
  localparam int DW        = ID_W + EN_W + STAMP_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ceb_cfg_t      cfg,
  ceb_in_if.sink             in_s,
  ceb_out_if.source          out_m,
  output      logic          ram_we,
  output      logic [AW-1:0] ram_waddr,
  output      logic [DW-1:0] ram_wdata,
  output      logic          ram_re,
  output      logic [AW-1:0] ram_raddr,
  input  wire logic [DW-1:0] ram_rdata
);

  localparam int CW = $clog2(MAX_HITS + 1);
  localparam int SB = STAMP_BITS;
  localparam logic [CW-1:0] FULL = CW'(MAX_HITS);
  localparam logic [CW-1:0] ONE  = CW'(1);

  typedef enum logic [2:0] {
    ST_ACCEPT = 3'b001,
    ST_RD     = 3'b010,
    ST_LD     = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [SB-1:0]      start_r, start_nxt;
  logic [CW-1:0]      hit_cnt_r, hit_cnt_nxt;
  logic [CW-1:0]      cry_cnt_r, cry_cnt_nxt;
  logic [EVNUM_W-1:0] evnum_r, evnum_nxt;
  logic               open_r, open_nxt;
  logic               ovf_r, ovf_nxt;
  logic [CW-1:0]      rd_k_r, rd_k_nxt;
  logic               pend_r, pend_nxt;
  logic [ID_W-1:0]    pend_id_r, pend_id_nxt;
  logic [EN_W-1:0]    pend_en_r, pend_en_nxt;
  logic [SB-1:0]      pend_t_r, pend_t_nxt;
  logic               pend_cry_r, pend_cry_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_load;
  logic [EVNUM_W-1:0]   out_evnum_r;
  logic [DW-1:0]        out_hit_r;
  logic [CNT_OUT_W-1:0] out_hits_r;
  logic [CNT_OUT_W-1:0] out_cry_r;
  logic                 out_last_r;
  logic                 out_drop_r;

  logic          accept;
  logic          joins;
  logic          is_cry;
  logic [SB-1:0] delta;
  logic          last_k;

  assign accept = in_s.valid && in_s.ready;
  assign delta  = in_s.hit_time - start_r;
  assign joins  = (in_s.hit_time < start_r) || (delta < SB'(cfg.window));
  assign is_cry = in_s.det_id < cfg.limit;
  assign last_k = (rd_k_r + ONE) == hit_cnt_r;

  assign in_s.ready = (state_r == ST_ACCEPT);

  always_comb begin
    state_nxt     = state_r;
    start_nxt     = start_r;
    hit_cnt_nxt   = hit_cnt_r;
    cry_cnt_nxt   = cry_cnt_r;
    evnum_nxt     = evnum_r;
    open_nxt      = open_r;
    ovf_nxt       = ovf_r;
    rd_k_nxt      = rd_k_r;
    pend_nxt      = pend_r;
    pend_id_nxt   = pend_id_r;
    pend_en_nxt   = pend_en_r;
    pend_t_nxt    = pend_t_r;
    pend_cry_nxt  = pend_cry_r;
    out_valid_nxt = out_valid_r && !out_m.ready;
    out_load      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = hit_cnt_r[AW-1:0];
    ram_wdata     = {in_s.det_id, in_s.energy, in_s.hit_time};
    ram_re        = 1'b0;
    ram_raddr     = rd_k_r[AW-1:0];

    case (state_r)
      ST_ACCEPT: begin
        if (accept) begin
          if (in_s.kind == KIND_FLUSH) begin
            if (open_r) begin
              pend_nxt  = 1'b0;
              rd_k_nxt  = '0;
              state_nxt = ST_RD;
            end
          end else if (open_r && !joins) begin
            // hold the closing hit until the event has been read out
            pend_nxt     = 1'b1;
            pend_id_nxt  = in_s.det_id;
            pend_en_nxt  = in_s.energy;
            pend_t_nxt   = in_s.hit_time;
            pend_cry_nxt = is_cry;
            rd_k_nxt     = '0;
            state_nxt    = ST_RD;
          end else begin
            if (!open_r) begin
              open_nxt  = 1'b1;
              start_nxt = in_s.hit_time;
            end
            if (hit_cnt_r == FULL) begin
              ovf_nxt = 1'b1;
            end else begin
              ram_we      = 1'b1;
              hit_cnt_nxt = hit_cnt_r + ONE;
              if (is_cry) begin
                cry_cnt_nxt = cry_cnt_r + ONE;
              end
            end
          end
        end
      end
      ST_RD: begin
        if (!out_valid_r || out_m.ready) begin
          ram_re    = 1'b1;
          state_nxt = ST_LD;
        end
      end
      ST_LD: begin
        out_load      = 1'b1;
        out_valid_nxt = 1'b1;
        if (last_k) begin
          evnum_nxt = evnum_r + 1'b1;
          ovf_nxt   = 1'b0;
          pend_nxt  = 1'b0;
          state_nxt = ST_ACCEPT;
          if (pend_r) begin
            ram_we      = 1'b1;
            ram_waddr   = '0;
            ram_wdata   = {pend_id_r, pend_en_r, pend_t_r};
            hit_cnt_nxt = ONE;
            cry_cnt_nxt = pend_cry_r ? ONE : '0;
            start_nxt   = pend_t_r;
            open_nxt    = 1'b1;
          end else begin
            hit_cnt_nxt = '0;
            cry_cnt_nxt = '0;
            open_nxt    = 1'b0;
          end
        end else begin
          rd_k_nxt  = rd_k_r + ONE;
          state_nxt = ST_RD;
        end
      end
      default: begin
        state_nxt = ST_ACCEPT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACCEPT;
      start_r     <= '0;
      hit_cnt_r   <= '0;
      cry_cnt_r   <= '0;
      evnum_r     <= '0;
      open_r      <= 1'b0;
      ovf_r       <= 1'b0;
      rd_k_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      cry_cnt_r   <= cry_cnt_nxt;
      evnum_r     <= evnum_nxt;
      open_r      <= open_nxt;
      ovf_r       <= ovf_nxt;
      rd_k_r      <= rd_k_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_id_r  <= pend_id_nxt;
    pend_en_r  <= pend_en_nxt;
    pend_t_r   <= pend_t_nxt;
    pend_cry_r <= pend_cry_nxt;
    if (out_load) begin
      out_evnum_r <= evnum_r;
      out_hit_r   <= ram_rdata;
      out_hits_r  <= CNT_OUT_W'(hit_cnt_r);
      out_cry_r   <= CNT_OUT_W'(cry_cnt_r);
      out_last_r  <= last_k;
      out_drop_r  <= ovf_r;
    end
  end

  assign out_m.valid              = out_valid_r;
  assign out_m.event_number       = out_evnum_r;
  assign out_m.hit_det_id         = out_hit_r[DW-1 -: ID_W];
  assign out_m.hit_energy         = out_hit_r[SB +: EN_W];
  assign out_m.hit_stamp          = out_hit_r[SB-1:0];
  assign out_m.event_hits         = out_hits_r;
  assign out_m.event_crystal_hits = out_cry_r;
  assign out_m.last_of_event      = out_last_r;
  assign out_m.hits_dropped       = out_drop_r;

  `CEB_ASSERT_NOW(a_ld_slot_free, clk, rst_n, state_r == ST_LD, !out_valid_r)
  `CEB_ASSERT_NOW(a_rd_open, clk, rst_n, state_r == ST_RD, open_r && (hit_cnt_r != '0))
  `CEB_ASSERT_NOW(a_ovf_full, clk, rst_n, ovf_r, hit_cnt_r == FULL)
  `CEB_ASSERT_NOW(a_cry_bound, clk, rst_n, open_r, cry_cnt_r <= hit_cnt_r)
  `CEB_ASSERT_NOW(a_no_rw_clash, clk, rst_n, ram_re, !ram_we)

endmodule

`default_nettype wire

FILE: rtl/coincidence_event_builder.sv
// ----------------------------------------------------------------------------
// Coincidence event builder
// Groups time-ordered detector hits into coincidence events. A hit that
// joins the open event, or opens one, is accepted and written to the
// hit RAM. A hit outside the window, or a flush word, closes the
// event: the stored hits are read back through the RAM's single read port
// and issued one word per stored hit, each read from the RAM and then
// loaded into the output register, waiting while the output is stalled.
// No new hit is taken while an event is read out. The closing hit is
// written back as the first entry of the next event on the last readout
// cycle. Hits past MAX_HITS in one event are dropped and flagged on every
// word of that event.
// ----------------------------------------------------------------------------
`default_nettype none

module coincidence_event_builder
  import ceb_pkg::*;
#(
  parameter int MAX_HITS   = MAX_HITS_DEF,
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ceb_cfg_if.sink    cfg_s,
  ceb_in_if.sink     in_s,
  ceb_out_if.source  out_m
);

  localparam int AW = $clog2(MAX_HITS);
  localparam int DW = ID_W + EN_W + STAMP_BITS;

  ceb_cfg_t cfg_r, cfg_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;

  assign cfg_s.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_s.valid && cfg_s.ready) begin
      case (cfg_s.index)
        REG_WINDOW: cfg_nxt.window = cfg_s.data;
        REG_LIMIT:  cfg_nxt.limit  = cfg_s.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window <= WINDOW_RST;
      cfg_r.limit  <= LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ceb_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_HITS)
  ) u_hit_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ceb_seq #(
    .MAX_HITS   (MAX_HITS),
    .STAMP_BITS (STAMP_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_s      (in_s),
    .out_m     (out_m),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

endmodule

`default_nettype wire
